// File: hdl/lph_pkg.sv
// Shared types and constants for the linear probing hash table.
package lph_pkg;

   localparam int CSR_W     = 11;
   localparam int FUNC_W    = 2;
   localparam int KEY_W     = 31;
   localparam int PAY_W     = 32;
   localparam int STAT_W    = 3;
   localparam int SLOT_W    = 10;
   localparam int TAG_W     = 2;
   localparam int DEPTH_DEF = 1024;

   localparam logic [CSR_W-1:0] TABLE_SIZE_RST = 11'd1024;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_SEARCH = 2'd2
   } func_type;

   typedef enum logic [TAG_W-1:0] {
      TAG_EMPTY   = 2'd0,
      TAG_USED    = 2'd1,
      TAG_DELETED = 2'd2
   } tag_type;

   typedef enum logic [STAT_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FOUND     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_READ,
      S_CHECK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       clr_we;
      logic       load;
      logic       pos_load;
      logic       step;
      logic       wr_tag;
      tag_type    tag_val;
      logic       wr_entry;
      logic       res_load;
      status_type res_status;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic mod_done;
      logic is_insert;
      logic is_delete;
      logic is_search;
      logic tag_used;
      logic tag_empty;
      logic key_match;
      logic last_probe;
      logic rsp_free;
   } sts_type;

endpackage

// File: hdl/lph_ram.sv
// Generic single write port RAM with registered read.
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/lph_mod.sv
// Iterative key modulo table size, one remainder bit per cycle.
module lph_mod import lph_pkg::*; #(
   parameter int SW = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   input  logic [SW-1:0]    size,
   output logic             done,
   output logic [SW-1:0]    rem
);

   localparam int CNT_W = $clog2(KEY_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEY_W - 1);

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [KEY_W-1:0] num_ff;
   logic [SW-1:0]    rem_ff;
   logic [SW:0]      shifted;
   logic [SW:0]      diff;
   logic [SW-1:0]    rem_in;

   always_comb begin
      shifted = {rem_ff, num_ff[KEY_W-1]};
      diff    = shifted - {1'b0, size};
      rem_in  = (shifted >= {1'b0, size}) ? diff[SW-1:0] : shifted[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_LAST);
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == CNT_LAST)) begin
            run_ff <= 1'b0;
         end
      end
      if (start) begin
         num_ff <= key;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[KEY_W-2:0], 1'b0};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   a_rem_below_size: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < size))
      else $error("remainder not below table size");

   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("modulo done held longer than one cycle");

endmodule

// File: hdl/lph_dp.sv
// Datapath: item registers, probe pointer, slot stores, result and output words.
module lph_dp import lph_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CSR_W-1:0]  table_size,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [PAY_W-1:0]  req_payload,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STAT_W-1:0] rsp_status,
   output logic [PAY_W-1:0]  rsp_found_payload,
   output logic [SLOT_W-1:0] rsp_slot_index
);

   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = AW + 1;
   localparam int CMP_W = (SW > CSR_W) ? SW : CSR_W;
   localparam int ENT_W = KEY_W + PAY_W;

   logic [FUNC_W-1:0] func_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [PAY_W-1:0]  pay_ff;
   logic [AW-1:0]     pos_ff;
   logic [AW-1:0]     pos_in;
   logic [AW-1:0]     cnt_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic [CMP_W-1:0]  size_ext;
   logic [SW-1:0]     size_use;
   logic [SW-1:0]     pos_nxt;
   logic              mod_done;
   logic [SW-1:0]     mod_rem;
   logic              tag_we;
   logic [AW-1:0]     tag_waddr;
   logic [TAG_W-1:0]  tag_wdata;
   logic [TAG_W-1:0]  tag_rd;
   logic [ENT_W-1:0]  ent_rd;
   logic [KEY_W-1:0]  rd_key;
   logic [PAY_W-1:0]  rd_pay;
   status_type        res_status_ff;
   logic [PAY_W-1:0]  res_pay_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [PAY_W-1:0]  rsp_pay_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   // size in use: zero counts as one, clamp at the store depth
   always_comb begin
      size_ext = CMP_W'(table_size);
      if (size_ext == '0) begin
         size_use = SW'(1);
      end else if (size_ext > CMP_W'(DEPTH)) begin
         size_use = SW'(DEPTH);
      end else begin
         size_use = size_ext[SW-1:0];
      end
   end

   lph_mod #(.SW(SW)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (cmd.load),
      .key   (req_key),
      .size  (size_use),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   always_comb begin
      pos_nxt = SW'(pos_ff) + 1'b1;
      if (cmd.pos_load) begin
         pos_in = mod_rem[AW-1:0];
      end else if (cmd.step) begin
         pos_in = (pos_nxt == size_use) ? '0 : pos_nxt[AW-1:0];
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_we) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
      if (cmd.load) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         pay_ff  <= req_payload;
      end
      pos_ff <= pos_in;
      if (cmd.pos_load) begin
         cnt_ff <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign tag_we    = cmd.clr_we || cmd.wr_tag;
   assign tag_waddr = cmd.clr_we ? clr_cnt_ff : pos_ff;
   assign tag_wdata = cmd.clr_we ? TAG_EMPTY : cmd.tag_val;

   lph_ram #(.WIDTH(TAG_W), .DEPTH(DEPTH)) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (tag_waddr),
      .wdata (tag_wdata),
      .raddr (pos_ff),
      .rdata (tag_rd)
   );

   lph_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ent_ram (
      .clock (clock),
      .we    (cmd.wr_entry),
      .waddr (pos_ff),
      .wdata ({key_ff, pay_ff}),
      .raddr (pos_ff),
      .rdata (ent_rd)
   );

   assign rd_key = ent_rd[ENT_W-1:PAY_W];
   assign rd_pay = ent_rd[PAY_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_pay_ff    <= (cmd.res_status == ST_FOUND) ? rd_pay : '0;
         if (cmd.res_status == ST_INSERTED || cmd.res_status == ST_DELETED ||
             cmd.res_status == ST_FOUND) begin
            res_slot_ff <= SLOT_W'(pos_ff);
         end else begin
            res_slot_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_pay_ff    <= res_pay_ff;
         rsp_slot_ff   <= res_slot_ff;
      end
   end

   always_comb begin
      sts.clr_last   = (clr_cnt_ff == AW'(DEPTH - 1));
      sts.mod_done   = mod_done;
      sts.is_insert  = (func_ff == FUNC_INSERT);
      sts.is_delete  = (func_ff == FUNC_DELETE);
      sts.is_search  = (func_ff == FUNC_SEARCH);
      sts.tag_used   = (tag_rd == TAG_USED);
      sts.tag_empty  = (tag_rd == TAG_EMPTY);
      sts.key_match  = (rd_key == key_ff);
      sts.last_probe = ((SW'(cnt_ff) + 1'b1) == size_use);
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_payload = rsp_pay_ff;
   assign rsp_slot_index    = rsp_slot_ff;

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (SW'(pos_ff) < size_use))
      else $error("probe pointer left the table");

   a_out_only_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && !cmd.out_load |=> rsp_valid_ff)
      else $error("stalled result word dropped");

endmodule

// File: hdl/lph_ctrl.sv
// Controller: clearing pass, modulo wait, probe sequence and result handoff.
module lph_ctrl import lph_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.tag_val    = TAG_EMPTY;
      cmd.res_status = ST_NOT_FOUND;
      req_stall      = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_we = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.mod_done) begin
               if (sts.is_insert || sts.is_delete || sts.is_search) begin
                  cmd.pos_load = 1'b1;
                  state_in     = S_READ;
               end else begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_RESP;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.is_insert) begin
               if (!sts.tag_used) begin
                  cmd.wr_tag     = 1'b1;
                  cmd.tag_val    = TAG_USED;
                  cmd.wr_entry   = 1'b1;
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_INSERTED;
                  state_in       = S_RESP;
               end else if (sts.last_probe) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_FULL;
                  state_in       = S_RESP;
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_READ;
               end
            end else begin
               if (sts.tag_empty) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_RESP;
               end else if (sts.tag_used && sts.key_match) begin
                  cmd.res_load = 1'b1;
                  state_in     = S_RESP;
                  if (sts.is_delete) begin
                     cmd.wr_tag     = 1'b1;
                     cmd.tag_val    = TAG_DELETED;
                     cmd.res_status = ST_DELETED;
                  end else begin
                     cmd.res_status = ST_FOUND;
                  end
               end else if (sts.last_probe) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_RESP;
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_accept_starts_mod: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DIV)
      else $error("accepted word did not start the modulo");

   a_entry_with_tag: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_entry |-> cmd.wr_tag && cmd.tag_val == TAG_USED)
      else $error("entry written without occupied tag");

   a_out_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.rsp_free)
      else $error("result loaded over a waiting word");

endmodule

// File: hdl/linear_probe_hash_table.sv
// Top level of the linear probing hash table.
//
// Request channel (req_valid / req_stall): one word per operation, req_func
// selects insert, delete or search on req_key; req_payload is stored on insert.
// Response channel (rsp_valid / rsp_stall): exactly one word per request with
// rsp_status, rsp_found_payload and rsp_slot_index.
// csr channel (csr_valid / csr_ready): writes table_size; always ready, write
// only while no request is in flight.
// Flow: key modulo table size in the shift-subtract unit, then the home slot
// is loaded, each probed slot takes a registered RAM read and then a compare,
// and the result is handed off. One request in flight at a time; the next is
// taken once the previous result sits in the output register.
// Reset: synchronous; table_size returns to 1024 and a clearing pass marks
// every slot empty, one slot per cycle, with req_stall high.
// A stalled response holds its word; a finished result then waits internally
// and the next request is not accepted until it moves to the output register.
module linear_probe_hash_table import lph_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [PAY_W-1:0]  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STAT_W-1:0] rsp_status,
   output logic [PAY_W-1:0]  rsp_found_payload,
   output logic [SLOT_W-1:0] rsp_slot_index,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_table_size
);

   logic [CSR_W-1:0] table_size_ff;
   cmd_type          cmd;
   sts_type          sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RST;
      end else if (csr_valid && csr_ready) begin
         table_size_ff <= csr_table_size;
      end
   end

   lph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lph_dp #(.DEPTH(DEPTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .table_size        (table_size_ff),
      .req_func          (req_func),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_payload (rsp_found_payload),
      .rsp_slot_index    (rsp_slot_index)
   );

endmodule
